[sv/xrr_pkg.sv]
// ---------------------------------------------------------------------------
// xrr_pkg: shared types and constants for the xorshift range generator
// Holds the word width, the generator seed, the request kinds and the
// command and status bundles between controller and datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package xrr_pkg;

    localparam int WORD_W     = 32;
    localparam int CNT_W      = $clog2(WORD_W);
    localparam int SHIFT_A    = 13;
    localparam int SHIFT_B    = 17;
    localparam int SHIFT_C    = 5;

    localparam logic [WORD_W-1:0] SEED_RESET = 32'd123456789;

    localparam logic [1:0] KIND_BELOW_MAX = 2'd0;
    localparam logic [1:0] KIND_CLOSED    = 2'd1;
    localparam logic [1:0] KIND_FIXED     = 2'd2;
    localparam logic [1:0] KIND_NONE      = 2'd3;

    typedef struct packed {
        logic load;
        logic advance;
        logic div_step;
        logic mul;
        logic out_load;
    } xrr_cmd_t;

    typedef struct packed {
        logic draw;
        logic use_div;
        logic use_mul;
    } xrr_status_t;

endpackage

`default_nettype wire

[sv/xrr_ctrl.sv]
// ---------------------------------------------------------------------------
// xrr_ctrl: request sequencer
// Steps each request through operand capture, setup, the remainder or
// multiply phase where the request needs one, and the hand-off into the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module xrr_ctrl
    import xrr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  wire logic        m_ready,
    input  wire xrr_status_t status,
    output xrr_cmd_t         cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SETUP = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_W - 1);

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                cmd.advance = status.draw;
                cnt_next    = '0;
                if (status.use_div) begin
                    state_next = ST_DIV;
                end else if (status.use_mul) begin
                    state_next = ST_MUL;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    state_next = ST_FIN;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                // The output register is free, or its beat leaves this cycle.
                if (!out_valid_reg || m_ready) begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_div_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && cnt_reg == CNT_LAST) |=> (state_reg == ST_FIN))
        else $error("remainder phase did not end after the last step");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!out_valid_reg || m_ready))
        else $error("output register loaded over a beat not yet taken");

    a_setup_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SETUP) |=>
            (state_reg == ST_DIV || state_reg == ST_MUL || state_reg == ST_FIN))
        else $error("setup went to an unexpected state");

    a_draw_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SETUP && !status.draw) |=> (state_reg == ST_FIN))
        else $error("request without a draw entered a compute phase");

endmodule

`default_nettype wire

[sv/xrr_dp.sv]
// ---------------------------------------------------------------------------
// xrr_dp: generator word, remainder unit and scaling multiplier
// Holds the xorshift word, a one-bit-per-cycle restoring remainder, a
// 32x32 multiplier for fixed-point scaling and the output registers.
// ---------------------------------------------------------------------------
`default_nettype none

module xrr_dp
    import xrr_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_write,
    input  wire logic        [WORD_W-1:0] cfg_seed_value,
    input  wire logic        [1:0]        s_kind,
    input  wire logic signed [WORD_W-1:0] s_low_bound,
    input  wire logic signed [WORD_W-1:0] s_high_bound,
    input  wire xrr_cmd_t                 cmd,
    output xrr_status_t                   status,
    output logic signed      [WORD_W-1:0] m_random_value,
    output logic                          m_drew_word
);

    logic [1:0]            kind_reg;
    logic [WORD_W-1:0]     lo_reg, hi_reg;
    logic [WORD_W-1:0]     word_reg, word_next;
    logic [WORD_W-1:0]     quo_reg;
    logic [WORD_W:0]       rem_reg, div_reg;
    logic [2*WORD_W-1:0]   prod_reg;
    logic [WORD_W-1:0]     out_value_reg, value_next;
    logic                  out_drew_reg;
    logic                  drew_reg;

    logic                  lo_lt_hi, hi_pos;
    logic [WORD_W+1:0]     span_wide;
    logic [WORD_W:0]       div_next;
    logic [WORD_W-1:0]     xs_a, xs_b, xs_c;
    logic [WORD_W+1:0]     shifted, trial;

    assign lo_lt_hi = ($signed(lo_reg) < $signed(hi_reg));
    assign hi_pos   = ($signed(hi_reg) > $signed({WORD_W{1'b0}}));

    always_comb begin
        status.draw    = 1'b0;
        status.use_div = 1'b0;
        status.use_mul = 1'b0;
        unique case (kind_reg)
            KIND_BELOW_MAX: begin
                status.draw    = hi_pos;
                status.use_div = hi_pos;
            end
            KIND_CLOSED: begin
                status.draw    = lo_lt_hi;
                status.use_div = lo_lt_hi;
            end
            KIND_FIXED: begin
                status.draw    = lo_lt_hi;
                status.use_mul = lo_lt_hi;
            end
            KIND_NONE: begin
                status.draw = 1'b0;
            end
            default: begin
                status.draw = 1'b0;
            end
        endcase
    end

    // The span is formed at 34 bits so that a full 2^32 range does not wrap.
    assign span_wide = {{2{hi_reg[WORD_W-1]}}, hi_reg} - {{2{lo_reg[WORD_W-1]}}, lo_reg};

    always_comb begin
        unique case (kind_reg)
            KIND_BELOW_MAX: div_next = {1'b0, hi_reg};
            KIND_CLOSED:    div_next = span_wide[WORD_W:0] + 1'b1;
            KIND_FIXED:     div_next = span_wide[WORD_W:0];
            KIND_NONE:      div_next = '0;
            default:        div_next = '0;
        endcase
    end

    assign xs_a = word_reg ^ (word_reg << SHIFT_A);
    assign xs_b = xs_a ^ (xs_a >> SHIFT_B);
    assign xs_c = xs_b ^ (xs_b << SHIFT_C);

    always_comb begin
        word_next = word_reg;
        if (cfg_write) begin
            word_next = cfg_seed_value;
        end else if (cmd.advance) begin
            word_next = xs_c;
        end
    end

    assign shifted = {rem_reg, quo_reg[WORD_W-1]};
    assign trial   = shifted - {1'b0, div_reg};

    always_comb begin
        value_next = '0;
        unique case (kind_reg)
            KIND_BELOW_MAX: value_next = drew_reg ? rem_reg[WORD_W-1:0] : '0;
            KIND_CLOSED:    value_next = drew_reg ? lo_reg + rem_reg[WORD_W-1:0] : lo_reg;
            KIND_FIXED:     value_next = drew_reg ? lo_reg + prod_reg[2*WORD_W-1:WORD_W]
                                                  : lo_reg;
            KIND_NONE:      value_next = '0;
            default:        value_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_reg <= SEED_RESET;
        end else begin
            word_reg <= word_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg <= s_kind;
            lo_reg   <= s_low_bound;
            hi_reg   <= s_high_bound;
        end
        if (cmd.advance) begin
            quo_reg <= xs_c;
            rem_reg <= '0;
            div_reg <= div_next;
        end else if (cmd.div_step) begin
            quo_reg <= quo_reg << 1;
            rem_reg <= trial[WORD_W+1] ? shifted[WORD_W:0] : trial[WORD_W:0];
        end
        if (cmd.load) begin
            drew_reg <= 1'b0;
        end else if (cmd.advance) begin
            drew_reg <= 1'b1;
        end
        if (cmd.mul) begin
            prod_reg <= word_reg * div_reg[WORD_W-1:0];
        end
        if (cmd.out_load) begin
            out_value_reg <= value_next;
            out_drew_reg  <= drew_reg;
        end
    end

    assign m_random_value = out_value_reg;
    assign m_drew_word    = out_drew_reg;

    a_no_draw_kind3: assert property (@(posedge aclk) disable iff (!aresetn)
        (kind_reg == KIND_NONE) |-> !status.draw)
        else $error("unused request kind asked for a draw");

    a_drew_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> (out_drew_reg == $past(drew_reg)))
        else $error("drew flag in output does not match the request");

    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_load && drew_reg && kind_reg != KIND_FIXED) |-> (rem_reg < div_reg))
        else $error("remainder not below divisor at hand-off");

endmodule

`default_nettype wire

[sv/xorshift_range_random.sv]
// ---------------------------------------------------------------------------
// xorshift_range_random: xorshift32 generator with range requests
// Top level: joins the request sequencer and the datapath.
// ---------------------------------------------------------------------------
// Each request returns one beat. A request that draws an integer value
// (kind 0 or 1) has its operands captured at the accepting edge. After
// that come setup and the word advance, the bit-serial remainder, and the
// load of the output. A fixed-point request (kind 2) uses the registered
// 32x32 multiply in place of the remainder. A request that draws nothing
// goes from setup straight to the output load. The sequencer is ready
// again in the cycle after the output load. One request is in work at a
// time, and a new one is accepted while the previous result still waits
// on the output. Writing the seed loads the generator word at once. The
// configuration channel is always ready. The user must see that it is
// written only while idle; the block itself does not enforce this.
`default_nettype none

module xorshift_range_random
    import xrr_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic        [WORD_W-1:0] cfg_seed_value,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic        [1:0]        s_kind,
    input  wire logic signed [WORD_W-1:0] s_low_bound,
    input  wire logic signed [WORD_W-1:0] s_high_bound,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic signed      [WORD_W-1:0] m_random_value,
    output logic                          m_drew_word
);

    xrr_cmd_t    cmd;
    xrr_status_t status;

    assign cfg_ready = 1'b1;

    xrr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    xrr_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_write      (cfg_valid && cfg_ready),
        .cfg_seed_value (cfg_seed_value),
        .s_kind         (s_kind),
        .s_low_bound    (s_low_bound),
        .s_high_bound   (s_high_bound),
        .cmd            (cmd),
        .status         (status),
        .m_random_value (m_random_value),
        .m_drew_word    (m_drew_word)
    );

endmodule

`default_nettype wire
